[hdl/utfd_pkg.sv]
package utfd_pkg;

    // field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEFT_W = 2;
    localparam int unsigned HALF_W = 10;

    // byte class masks and patterns
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;

    // continuation counts opened by each lead class
    localparam logic [LEFT_W-1:0] LEFT_NONE  = 2'd0;
    localparam logic [LEFT_W-1:0] LEFT_ONE   = 2'd1;
    localparam logic [LEFT_W-1:0] LEFT_TWO   = 2'd2;
    localparam logic [LEFT_W-1:0] LEFT_THREE = 2'd3;

    // surrogate ranges
    localparam logic [CP_W-1:0] SUR_FIRST  = 21'h00D800;
    localparam logic [CP_W-1:0] HIGH_LAST  = 21'h00DBFF;
    localparam logic [CP_W-1:0] LOW_FIRST  = 21'h00DC00;
    localparam logic [CP_W-1:0] SUR_LAST   = 21'h00DFFF;
    localparam logic [CP_W-1:0] SUPP_BASE  = 21'h010000;

endpackage

[hdl/utfd_if.sv]
// byte channel into the decoder
interface utfd_in_if
    import utfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              stream_end;

    modport source (output valid, output byte_value, output stream_end, input ready);
    modport sink   (input valid, input byte_value, input stream_end, output ready);
endinterface

// code point channel out of the decoder
interface utfd_out_if
    import utfd_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            end_marker;

    modport source (output valid, output code_point, output end_marker, input ready);
    modport sink   (input valid, input code_point, input end_marker, output ready);
endinterface

[hdl/utf8_decoder_with_surrogate_join.sv]
// UTF-8 byte stream decoder that joins UTF-16 surrogate pairs. One byte item is taken
// per clock and a code point item appears in the cycle after the byte that ends a
// sequence; bytes that open or continue a sequence, stray continuations, bytes F8-FF,
// lone low surrogates and held high surrogates produce no item. The decode state and
// the one-entry result register are updated in the same cycle an item is accepted, so
// the block sustains one item per cycle; the input stalls only while the result
// register is full and the sink is not taking it. An item with stream_end set clears
// all pending state and returns an end marker with code point zero. Overlong forms are
// passed through, so values up to 1FFFFF can appear.
module utf8_decoder_with_surrogate_join
    import utfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    utfd_in_if.sink    i_in,
    utfd_out_if.source o_out
);

    logic [LEFT_W-1:0] r_bytes_left, n_bytes_left;
    logic [CP_W-1:0]   r_partial, n_partial;
    logic [HALF_W-1:0] r_high_half, n_high_half;
    logic              r_high_held, n_high_held;
    logic              r_out_valid, n_out_valid;
    logic [CP_W-1:0]   r_out_code, n_out_code;
    logic              r_out_end, n_out_end;

    logic              in_acc;
    logic [BYTE_W-1:0] b;
    logic              is_cont;
    logic              dec_valid;
    logic [CP_W-1:0]   dec_value;
    logic [CP_W-1:0]   shifted;
    logic              emit;
    logic [CP_W-1:0]   emit_value;

    // handshake: accept while the result register is empty or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    assign b       = i_in.byte_value;
    assign is_cont = (b & CONT_MASK) == CONT_PAT;
    assign shifted = {r_partial[CP_W-7:0], b[5:0]};

    // byte decode: sequence tracking and completed value
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_partial    = r_partial;
        dec_valid    = 1'b0;
        dec_value    = '0;
        if (r_bytes_left != LEFT_NONE && is_cont) begin
            n_bytes_left = r_bytes_left - LEFT_ONE;
            if (r_bytes_left == LEFT_ONE) begin
                dec_valid = 1'b1;
                dec_value = shifted;
                n_partial = '0;
            end else begin
                n_partial = shifted;
            end
        end else begin
            // no sequence open, or an interrupted one: treat as a new lead
            n_bytes_left = LEFT_NONE;
            n_partial    = '0;
            if (!b[7]) begin
                dec_valid = 1'b1;
                dec_value = {{(CP_W-BYTE_W){1'b0}}, b};
            end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
                n_partial    = {{(CP_W-5){1'b0}}, b[4:0]};
                n_bytes_left = LEFT_ONE;
            end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
                n_partial    = {{(CP_W-4){1'b0}}, b[3:0]};
                n_bytes_left = LEFT_TWO;
            end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
                n_partial    = {{(CP_W-3){1'b0}}, b[2:0]};
                n_bytes_left = LEFT_THREE;
            end
        end
    end

    // surrogate handling on a completed value
    always_comb begin
        n_high_half = r_high_half;
        n_high_held = r_high_held;
        emit        = 1'b0;
        emit_value  = dec_value;
        if (dec_valid) begin
            if (r_high_held && dec_value >= LOW_FIRST && dec_value <= SUR_LAST) begin
                emit        = 1'b1;
                emit_value  = {1'b0, r_high_half, dec_value[HALF_W-1:0]} + SUPP_BASE;
                n_high_half = '0;
                n_high_held = 1'b0;
            end else begin
                n_high_half = '0;
                n_high_held = 1'b0;
                if (dec_value < SUR_FIRST || dec_value > SUR_LAST) begin
                    emit = 1'b1;
                end else if (dec_value <= HIGH_LAST) begin
                    n_high_half = dec_value[HALF_W-1:0];
                    n_high_held = 1'b1;
                end
            end
        end
    end

    // result register next values
    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_code  = r_out_code;
        n_out_end   = r_out_end;
        if (in_acc) begin
            if (i_in.stream_end) begin
                n_out_valid = 1'b1;
                n_out_code  = '0;
                n_out_end   = 1'b1;
            end else if (emit) begin
                n_out_valid = 1'b1;
                n_out_code  = emit_value;
                n_out_end   = 1'b0;
            end
        end
    end

    // decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= LEFT_NONE;
            r_partial    <= '0;
            r_high_half  <= '0;
            r_high_held  <= 1'b0;
        end else if (in_acc) begin
            if (i_in.stream_end) begin
                r_bytes_left <= LEFT_NONE;
                r_partial    <= '0;
                r_high_half  <= '0;
                r_high_held  <= 1'b0;
            end else begin
                r_bytes_left <= n_bytes_left;
                r_partial    <= n_partial;
                r_high_half  <= n_high_half;
                r_high_held  <= n_high_held;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_code <= n_out_code;
        r_out_end  <= n_out_end;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.code_point = r_out_code;
    assign o_out.end_marker = r_out_end;

    // an end item leaves clean state and an end marker waiting
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.stream_end) |=>
            (r_bytes_left == LEFT_NONE && !r_high_held && r_out_valid && r_out_end))
        else $error("end item did not clear state");

    // an end marker always carries code point zero
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> (r_out_code == '0))
        else $error("end marker with non-zero code point");

    // no partial value survives without an open sequence
    a_partial_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_left == LEFT_NONE) |-> (r_partial == '0))
        else $error("partial value left with no open sequence");

    // high half is cleared whenever no surrogate is held
    a_half_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_high_held |-> (r_high_half == '0))
        else $error("stale high half");

endmodule
